@@ rtl/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement package
// Sizes, register indexes and sequencer state codes shared by the channel
// interfaces, the replacement unit and its checker.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;

    // Fixed field widths of the channels and the configuration port.
    localparam int PAGE_W       = 16;
    localparam int OUT_IDX_W    = 4;
    localparam int FAULT_W      = 32;
    localparam int NUM_FRAMES_W = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    // Frame index and frame count widths follow from the frame count.
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    localparam logic [CFG_IDX_W-1:0] REG_NUM_FRAMES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_USE_BIT = 1'd1;

    localparam logic [NUM_FRAMES_W-1:0] NUM_FRAMES_RST = 5'd16;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_WALK  = 3'b100
    } t_state;

endpackage

@@ rtl/cpr_in_if.sv @@
// ----------------------------------------------------------------------------
// Page reference channel
// Valid/ready channel that carries one page reference per transfer.
// ----------------------------------------------------------------------------
interface cpr_in_if;
    import cpr_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;
    logic              last_in_trace;

    modport source (output valid, page_number, last_in_trace, input ready);
    modport sink   (input valid, page_number, last_in_trace, output ready);

endinterface

@@ rtl/cpr_out_if.sv @@
// ----------------------------------------------------------------------------
// Replacement result channel
// Valid/ready channel that carries one replacement result per transfer.
// ----------------------------------------------------------------------------
interface cpr_out_if;
    import cpr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [OUT_IDX_W-1:0] frame_index;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [FAULT_W-1:0]   fault_count;

    modport source (output valid, hit, frame_index, evicted_valid, evicted_page,
                    fault_count, input ready);
    modport sink   (input valid, hit, frame_index, evicted_valid, evicted_page,
                    fault_count, output ready);

endinterface

@@ rtl/clock_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement unit
// Matches each page reference against the resident frames, then on a fault
// walks the clock hand one frame per cycle to pick a victim, holding at a full output.
// ----------------------------------------------------------------------------
// A hit is registered at the output from the match state. On a fault the walk
// examines frames from the hand onward, at most the active frame count plus one,
// before the victim's result is registered. The next reference is taken once the
// result is registered and the unit is back in idle; a hit or a victim waits in
// its state while the previous result is held at a full output.
// Reset (synchronous, active low) empties all frames, zeroes the hand and the
// fault count, and sets num_frames to 16 and new_use_bit to 1.
module clock_page_replacement_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cpr_in_if.sink                          i_req,
    cpr_out_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [cpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cpr_pkg::*;

    t_state                  r_state, n_state;
    logic [NUM_FRAMES_W-1:0] r_num_frames, n_num_frames;
    logic                    r_new_use, n_new_use;

    logic [PAGE_BITS-1:0]    r_frame_page [FRAMES];
    logic [PAGE_BITS-1:0]    n_frame_page [FRAMES];
    logic [FRAMES-1:0]       r_valid, n_valid;
    logic [FRAMES-1:0]       r_use, n_use;
    logic [IDX_W-1:0]        r_hand, n_hand;
    logic [IDX_W-1:0]        r_h, n_h;
    logic [FAULT_W-1:0]      r_faults, n_faults;

    logic [PAGE_BITS-1:0]    r_page, n_page;
    logic                    r_last, n_last;

    logic                    r_o_valid, n_o_valid;
    logic                    r_o_hit, n_o_hit;
    logic [IDX_W-1:0]        r_o_where, n_o_where;
    logic                    r_o_ev_valid, n_o_ev_valid;
    logic [PAGE_W-1:0]       r_o_ev_page, n_o_ev_page;
    logic [FAULT_W-1:0]      r_o_faults, n_o_faults;

    logic [CNT_W-1:0]        w_nact;
    logic [FRAMES-1:0]       w_match;
    logic                    w_hit;
    logic [IDX_W-1:0]        w_first;
    logic                    w_out_free;
    logic [IDX_W-1:0]        w_h_next;
    logic [FAULT_W-1:0]      w_faults_inc;
    logic                    w_done;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.frame_index   = OUT_IDX_W'(r_o_where);
    assign o_rsp.evicted_valid = r_o_ev_valid;
    assign o_rsp.evicted_page  = r_o_ev_page;
    assign o_rsp.fault_count   = r_o_faults;

    always_comb begin
        // Clamp the frame count to 1..FRAMES.
        if (r_num_frames == '0) begin
            w_nact = CNT_W'(1);
        end else if (int'(r_num_frames) > FRAMES) begin
            w_nact = CNT_W'(FRAMES);
        end else begin
            w_nact = CNT_W'(r_num_frames);
        end

        for (int i = 0; i < FRAMES; i++) begin
            w_match[i] = r_valid[i] && (r_frame_page[i] == r_page) && (i < int'(w_nact));
        end
        w_hit = |w_match;

        // Scan downward so the lowest matching frame is the one kept.
        w_first = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = IDX_W'(i);
            end
        end

        w_out_free   = !r_o_valid || o_rsp.ready;
        w_h_next     = ((CNT_W'(r_h) + CNT_W'(1)) < w_nact) ? r_h + IDX_W'(1) : '0;
        w_faults_inc = (r_faults == '1) ? r_faults : r_faults + FAULT_W'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_num_frames = r_num_frames;
        n_new_use    = r_new_use;
        n_frame_page = r_frame_page;
        n_valid      = r_valid;
        n_use        = r_use;
        n_hand       = r_hand;
        n_h          = r_h;
        n_faults     = r_faults;
        n_page       = r_page;
        n_last       = r_last;
        n_o_valid    = r_o_valid;
        n_o_hit      = r_o_hit;
        n_o_where    = r_o_where;
        n_o_ev_valid = r_o_ev_valid;
        n_o_ev_page  = r_o_ev_page;
        n_o_faults   = r_o_faults;
        w_done       = 1'b0;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_FRAMES:  n_num_frames = i_cfg_data[NUM_FRAMES_W-1:0];
                REG_NEW_USE_BIT: n_new_use    = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_page  = PAGE_BITS'(i_req.page_number);
                    n_last  = i_req.last_in_trace;
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                if (w_hit) begin
                    // Use bits are set only once the output is free; waiting changes nothing.
                    if (w_out_free) begin
                        n_use        = r_use | w_match;
                        n_o_valid    = 1'b1;
                        n_o_hit      = 1'b1;
                        n_o_where    = w_first;
                        n_o_ev_valid = 1'b0;
                        n_o_ev_page  = '0;
                        n_o_faults   = r_faults;
                        w_done       = 1'b1;
                    end
                end else begin
                    n_h     = (CNT_W'(r_hand) < w_nact) ? r_hand : '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!r_valid[r_h] || !r_use[r_h]) begin
                    if (w_out_free) begin
                        n_frame_page[r_h] = r_page;
                        n_valid[r_h]      = 1'b1;
                        n_use[r_h]        = r_new_use;
                        n_hand            = w_h_next;
                        n_faults          = w_faults_inc;
                        n_o_valid         = 1'b1;
                        n_o_hit           = 1'b0;
                        n_o_where         = r_h;
                        n_o_ev_valid      = r_valid[r_h];
                        n_o_ev_page       = r_valid[r_h] ? PAGE_W'(r_frame_page[r_h]) : '0;
                        n_o_faults        = w_faults_inc;
                        w_done            = 1'b1;
                    end
                end else begin
                    // Second chance: clear the use bit and move on to the next frame.
                    n_use[r_h] = 1'b0;
                    n_h        = w_h_next;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_done) begin
            n_state = S_IDLE;
            if (r_last) begin
                n_valid  = '0;
                n_use    = '0;
                n_hand   = '0;
                n_faults = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_frames <= NUM_FRAMES_RST;
            r_new_use    <= 1'b1;
            r_valid      <= '0;
            r_use        <= '0;
            r_hand       <= '0;
            r_faults     <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_num_frames <= n_num_frames;
            r_new_use    <= n_new_use;
            r_valid      <= n_valid;
            r_use        <= n_use;
            r_hand       <= n_hand;
            r_faults     <= n_faults;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame_page <= n_frame_page;
        r_h          <= n_h;
        r_page       <= n_page;
        r_last       <= n_last;
        r_o_hit      <= n_o_hit;
        r_o_where    <= n_o_where;
        r_o_ev_valid <= n_o_ev_valid;
        r_o_ev_page  <= n_o_ev_page;
        r_o_faults   <= n_o_faults;
    end

endmodule

@@ rtl/cpr_checker.sv @@
// ----------------------------------------------------------------------------
// Clock page replacement checker
// Port-level assertions on the replacement unit, attached by a bind.
// ----------------------------------------------------------------------------
module cpr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_hit,
    input logic                        i_evicted_valid,
    input logic [cpr_pkg::PAGE_W-1:0]  i_evicted_page,
    input logic [cpr_pkg::FAULT_W-1:0] i_fault_count
);
    import cpr_pkg::*;

    // One reference is worked on at a time.
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("reference taken while the previous one is still at work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before its transfer");

    // A hit never evicts, and no eviction reports a page.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> !i_evicted_valid)
        else $error("hit reported with an eviction");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_evicted_valid |-> i_evicted_page == '0)
        else $error("evicted page not zero without an eviction");

    // A fault is counted before its result is shown.
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_hit |-> i_fault_count != '0)
        else $error("fault result with a zero fault count");

endmodule

bind clock_page_replacement_unit cpr_checker u_cpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_hit           (o_rsp.hit),
    .i_evicted_valid (o_rsp.evicted_valid),
    .i_evicted_page  (o_rsp.evicted_page),
    .i_fault_count   (o_rsp.fault_count)
);
